// ----- rtl/mcht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcht_pkg
// Shared constants, codes and control types of the MAC class hash table.
// ----------------------------------------------------------------------------
package mcht_pkg;

  localparam int SLOTS_DEF   = 1024;
  localparam int BUCKETS_DEF = 256;

  localparam int KEY_W    = 48;
  localparam int CLASS_W  = 16;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UPDATED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REMOVED     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_REMOVE_MISS = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic                clr;       // clearing pass write
    logic                load;      // take the request beat, read bucket head
    logic                set_head;  // capture chain head as current slot
    logic                rd_walk;   // read key and next link of current slot
    logic                adv;       // step to next link
    logic                rd_class;  // read class of current slot
    logic                upd;       // overwrite class of current slot
    logic                rd_links;  // read prev and next link of current slot
    logic                rm_link;   // unlink current slot from its neighbors
    logic                rm_free;   // clear links, push slot on free stack
    logic                rd_free;   // read free link of free head
    logic                ins;       // pop free head, write entry at chain head
    logic                ins_prev;  // back-link old chain head
    logic                res_en;    // capture result code
    logic [STATUS_W-1:0] res_code;
    logic                out_load;  // move result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic                req_valid;
    logic                clear_done;
    logic                head_zero;
    logic                match;
    logic                next_zero;
    logic                free_empty;
    logic                out_free;
    logic [ACTION_W-1:0] action;
  } stat_t;

endpackage

// ----- rtl/mcht_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcht_req_if
// Request channel: one table operation per beat.
// ----------------------------------------------------------------------------
interface mcht_req_if;
  logic                            valid;
  logic                            ready;
  logic [mcht_pkg::ACTION_W-1:0]   action;
  logic [mcht_pkg::KEY_W-1:0]      mac_key;
  logic [mcht_pkg::CLASS_W-1:0]    user_class;

  modport source (output valid, action, mac_key, user_class, input ready);
  modport sink   (input valid, action, mac_key, user_class, output ready);
endinterface

// ----- rtl/mcht_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcht_rsp_if
// Response channel: one status beat per request.
// ----------------------------------------------------------------------------
interface mcht_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [mcht_pkg::STATUS_W-1:0]   status;
  logic [mcht_pkg::CLASS_W-1:0]    class_out;

  modport source (output valid, status, class_out, input ready);
  modport sink   (input valid, status, class_out, output ready);
endinterface

// ----- rtl/mcht_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcht_dp
// Datapath: entry, link and bucket memories, free stack head, result register.
// ----------------------------------------------------------------------------
module mcht_dp #(
  parameter int SLOTS   = mcht_pkg::SLOTS_DEF,
  parameter int BUCKETS = mcht_pkg::BUCKETS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  mcht_pkg::cmd_t  cmd,
  output mcht_pkg::stat_t stat,
  mcht_req_if.sink        req,
  mcht_rsp_if.source      rsp
);

  localparam int IW   = $clog2(SLOTS);
  localparam int BW   = $clog2(BUCKETS);
  localparam int MAXN = (SLOTS > BUCKETS) ? SLOTS : BUCKETS;
  localparam int CW   = $clog2(MAXN);

  logic [mcht_pkg::KEY_W-1:0]   entry_key   [SLOTS];
  logic [mcht_pkg::CLASS_W-1:0] entry_class [SLOTS];
  logic [IW-1:0]                chain_next  [SLOTS];
  logic [IW-1:0]                chain_prev  [SLOTS];
  logic [IW-1:0]                free_next   [SLOTS];
  logic [IW-1:0]                bucket_head [BUCKETS];

  logic [mcht_pkg::KEY_W-1:0]    key_rd;
  logic [mcht_pkg::CLASS_W-1:0]  class_rd;
  logic [IW-1:0]                 next_rd, prev_rd, free_rd, head_rd;

  logic [mcht_pkg::ACTION_W-1:0] action;
  logic [mcht_pkg::KEY_W-1:0]    key;
  logic [mcht_pkg::CLASS_W-1:0]  cls;
  logic [BW-1:0]                 bkt;
  logic [IW-1:0]                 cur, head, free_head;
  logic [CW-1:0]                 clr_cnt;
  logic [mcht_pkg::STATUS_W-1:0] res_code;
  logic [mcht_pkg::CLASS_W-1:0]  res_class;

  logic [BW-1:0] bkt_in;
  logic [IW-1:0] clr_slot;
  logic [BW-1:0] clr_bkt;
  logic          clr_in_slots, clr_in_bkts;
  logic [IW-1:0] clr_free;

  assign bkt_in       = BW'(32'(req.mac_key[7:0]) % BUCKETS);
  assign clr_slot     = IW'(clr_cnt);
  assign clr_bkt      = BW'(clr_cnt);
  assign clr_in_slots = 32'(clr_cnt) < SLOTS;
  assign clr_in_bkts  = 32'(clr_cnt) < BUCKETS;
  assign clr_free     = (clr_cnt != '0 && 32'(clr_cnt) + 32'd1 < SLOTS)
                        ? IW'(32'(clr_cnt) + 32'd1) : '0;

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr && 32'(clr_cnt) != MAXN - 1) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // request fields and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action <= req.action;
      key    <= req.mac_key;
      cls    <= req.user_class;
      bkt    <= bkt_in;
    end
    if (cmd.set_head) begin
      head <= head_rd;
      cur  <= head_rd;
    end else if (cmd.adv) begin
      cur <= next_rd;
    end else if (cmd.ins) begin
      cur <= free_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= IW'(1);
    end else if (cmd.rm_free) begin
      free_head <= cur;
    end else if (cmd.ins) begin
      free_head <= free_rd;
    end
  end

  // bucket heads
  always_ff @(posedge clk) begin
    if (cmd.clr && clr_in_bkts) begin
      bucket_head[clr_bkt] <= '0;
    end else if (cmd.rm_link && prev_rd == '0) begin
      bucket_head[bkt] <= next_rd;
    end else if (cmd.ins) begin
      bucket_head[bkt] <= free_head;
    end
    if (cmd.load) begin
      head_rd <= bucket_head[bkt_in];
    end
  end

  // forward links
  always_ff @(posedge clk) begin
    if (cmd.clr && clr_in_slots) begin
      chain_next[clr_slot] <= '0;
    end else if (cmd.rm_link && prev_rd != '0) begin
      chain_next[prev_rd] <= next_rd;
    end else if (cmd.rm_free) begin
      chain_next[cur] <= '0;
    end else if (cmd.ins) begin
      chain_next[free_head] <= head;
    end
    if (cmd.rd_walk || cmd.rd_links) begin
      next_rd <= chain_next[cur];
    end
  end

  // back links
  always_ff @(posedge clk) begin
    if (cmd.clr && clr_in_slots) begin
      chain_prev[clr_slot] <= '0;
    end else if (cmd.rm_link && next_rd != '0) begin
      chain_prev[next_rd] <= prev_rd;
    end else if (cmd.rm_free) begin
      chain_prev[cur] <= '0;
    end else if (cmd.ins) begin
      chain_prev[free_head] <= '0;
    end else if (cmd.ins_prev && head != '0) begin
      chain_prev[head] <= cur;
    end
    if (cmd.rd_links) begin
      prev_rd <= chain_prev[cur];
    end
  end

  // free stack links
  always_ff @(posedge clk) begin
    if (cmd.clr && clr_in_slots) begin
      free_next[clr_slot] <= clr_free;
    end else if (cmd.rm_free) begin
      free_next[cur] <= free_head;
    end else if (cmd.ins) begin
      free_next[free_head] <= '0;
    end
    if (cmd.rd_free) begin
      free_rd <= free_next[free_head];
    end
  end

  // entry store
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      entry_key[free_head] <= key;
    end
    if (cmd.rd_walk) begin
      key_rd <= entry_key[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      entry_class[cur] <= cls;
    end else if (cmd.ins) begin
      entry_class[free_head] <= cls;
    end
    if (cmd.rd_class) begin
      class_rd <= entry_class[cur];
    end
  end

  // result and output register
  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      res_code  <= cmd.res_code;
      res_class <= (cmd.res_code == mcht_pkg::ST_HIT) ? class_rd : '0;
    end
    if (cmd.out_load) begin
      rsp.status    <= res_code;
      rsp.class_out <= res_class;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  assign stat.req_valid  = req.valid;
  assign stat.clear_done = 32'(clr_cnt) == MAXN - 1;
  assign stat.head_zero  = head_rd == '0;
  assign stat.match      = key_rd == key;
  assign stat.next_zero  = next_rd == '0;
  assign stat.free_empty = free_head == '0;
  assign stat.out_free   = !rsp.valid || rsp.ready;
  assign stat.action     = action;

endmodule

// ----- rtl/mcht_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcht_ctrl
// Controller: sequences clear pass, chain walk, update, insert and remove.
// ----------------------------------------------------------------------------
module mcht_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  mcht_pkg::stat_t stat,
  output mcht_pkg::cmd_t  cmd,
  output logic            req_ready
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HEAD   = 4'd2;
  localparam logic [3:0] S_WALK   = 4'd3;
  localparam logic [3:0] S_CMP    = 4'd4;
  localparam logic [3:0] S_FOUND  = 4'd5;
  localparam logic [3:0] S_CLS    = 4'd6;
  localparam logic [3:0] S_RM1    = 4'd7;
  localparam logic [3:0] S_RM2    = 4'd8;
  localparam logic [3:0] S_NF     = 4'd9;
  localparam logic [3:0] S_INS1   = 4'd10;
  localparam logic [3:0] S_INS2   = 4'd11;
  localparam logic [3:0] S_RESULT = 4'd12;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (stat.req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.set_head = 1'b1;
        state_next   = stat.head_zero ? S_NF : S_WALK;
      end
      S_WALK: begin
        cmd.rd_walk = 1'b1;
        state_next  = S_CMP;
      end
      S_CMP: begin
        if (stat.match) begin
          state_next = S_FOUND;
        end else begin
          cmd.adv    = 1'b1;
          state_next = stat.next_zero ? S_NF : S_WALK;
        end
      end
      S_FOUND: begin
        case (stat.action)
          mcht_pkg::ACT_LOOKUP: begin
            cmd.rd_class = 1'b1;
            state_next   = S_CLS;
          end
          mcht_pkg::ACT_INSERT: begin
            cmd.upd      = 1'b1;
            cmd.res_en   = 1'b1;
            cmd.res_code = mcht_pkg::ST_UPDATED;
            state_next   = S_RESULT;
          end
          mcht_pkg::ACT_REMOVE: begin
            cmd.rd_links = 1'b1;
            state_next   = S_RM1;
          end
          default: begin
            cmd.res_en   = 1'b1;
            cmd.res_code = mcht_pkg::ST_MISS;
            state_next   = S_RESULT;
          end
        endcase
      end
      S_CLS: begin
        cmd.res_en   = 1'b1;
        cmd.res_code = mcht_pkg::ST_HIT;
        state_next   = S_RESULT;
      end
      S_RM1: begin
        cmd.rm_link = 1'b1;
        state_next  = S_RM2;
      end
      S_RM2: begin
        cmd.rm_free  = 1'b1;
        cmd.res_en   = 1'b1;
        cmd.res_code = mcht_pkg::ST_REMOVED;
        state_next   = S_RESULT;
      end
      S_NF: begin
        cmd.res_en = 1'b1;
        state_next = S_RESULT;
        case (stat.action)
          mcht_pkg::ACT_INSERT: begin
            if (stat.free_empty) begin
              cmd.res_code = mcht_pkg::ST_FULL;
            end else begin
              cmd.res_en  = 1'b0;
              cmd.rd_free = 1'b1;
              state_next  = S_INS1;
            end
          end
          mcht_pkg::ACT_REMOVE: cmd.res_code = mcht_pkg::ST_REMOVE_MISS;
          default:              cmd.res_code = mcht_pkg::ST_MISS;
        endcase
      end
      S_INS1: begin
        cmd.ins    = 1'b1;
        state_next = S_INS2;
      end
      S_INS2: begin
        cmd.ins_prev = 1'b1;
        cmd.res_en   = 1'b1;
        cmd.res_code = mcht_pkg::ST_INSERTED;
        state_next   = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// ----- rtl/mac_class_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_class_hash_table
// Chained hash table of 16-bit class codes keyed by 48-bit MAC addresses.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per beat: action (lookup, insert or update,
//   remove), mac_key and user_class. rsp returns exactly one beat per
//   request with status and class_out (class only on a lookup hit).
//   The low MAC byte, modulo BUCKETS, selects a chain; chains are doubly
//   linked by slot index; unused slots but slot 0 (null) sit on a free stack.
// Timing:
//   One operation at a time. req.ready is high only while idle. A lookup
//   hit reads the bucket head, walks the chain to the match, reads the
//   class and then loads the response beat; each walk step costs one
//   registered memory read plus one compare. A miss walks the whole chain.
//   An update writes the class instead of reading it, an insert of a new
//   key pops the free stack after the miss and links the slot as chain
//   head, a remove reads the links, unlinks the slot and frees it. req.ready
//   returns as the response beat appears.
// Reset:
//   After rst the block runs a clearing pass over indexes 0 to
//   max(SLOTS, BUCKETS) - 1 that empties every chain and rebuilds the free
//   stack; req.ready stays low until it ends.
// Stall:
//   A response beat holds in the output register until rsp.ready; the next
//   request is taken only after that beat has moved into the register.
// ----------------------------------------------------------------------------
module mac_class_hash_table #(
  parameter int SLOTS   = mcht_pkg::SLOTS_DEF,
  parameter int BUCKETS = mcht_pkg::BUCKETS_DEF
) (
  input logic        clk,
  input logic        rst,
  mcht_req_if.sink   req,
  mcht_rsp_if.source rsp
);

  mcht_pkg::cmd_t  cmd;
  mcht_pkg::stat_t stat;
  logic            req_ready;

  // controller drives the request handshake, datapath the response beat
  assign req.ready = req_ready;

  mcht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .cmd       (cmd),
    .req_ready (req_ready)
  );

  mcht_dp #(
    .SLOTS   (SLOTS),
    .BUCKETS (BUCKETS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

endmodule

// ----- rtl/mcht_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcht_checker
// Port-level checks of the MAC class hash table.
// ----------------------------------------------------------------------------
module mcht_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [mcht_pkg::STATUS_W-1:0] status,
  input logic [mcht_pkg::CLASS_W-1:0]  class_out
);

  // no beat leaves right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response beat right after reset");

  // one request in flight: no back-to-back accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while busy");

  // stalled response holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(class_out)))
    else $error("stalled response changed");

  // class only on a hit
  a_class_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != mcht_pkg::ST_HIT) |-> class_out == '0)
    else $error("class on non-hit status");

  // status code in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= mcht_pkg::ST_REMOVE_MISS)
    else $error("undefined status code");

endmodule

bind mac_class_hash_table mcht_checker u_mcht_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .class_out (rsp.class_out)
);
